// ----- src/gfs_pkg.sv -----
// Shared types, constants and a helper function for the disk geometry block.
package gfs_pkg;

  localparam int TOTAL_W = 31;
  localparam int DIVR_W  = 13;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_RDB   = 2'd1;

  localparam logic [4:0] HEADS_MIN  = 5'd4;
  localparam logic [4:0] HEADS_MAX  = 5'd16;
  localparam logic [4:0] HEADS_NONE = 5'd17;
  localparam logic [4:0] RDB_HEAD_COUNT = 5'd1;
  localparam logic [7:0] RDB_SPT    = 8'd32;
  localparam logic [1:0] SPT_LAST_IDX = 2'd2;

  localparam logic [TOTAL_W-1:0] SMALL_IMAGE_SECTORS = 31'd1048576;
  localparam logic [TOTAL_W-1:0] SMALL_CYL_MAX       = 31'd1023;
  localparam logic [TOTAL_W-1:0] CYL_LIMIT_A         = 31'd16383;
  localparam logic [TOTAL_W-1:0] CYL_LIMIT_B         = 31'd32767;
  localparam logic [TOTAL_W-1:0] CYL_LIMIT_C         = 31'd65535;

  typedef struct packed {
    logic [39:0] image_bytes;
    logic [1:0]  image_mode;
  } gfs_in_t;

  typedef struct packed {
    logic        updated;
    logic [15:0] cylinders;
    logic [4:0]  heads;
    logic [7:0]  sectors_per_track;
    logic        overflow;
  } gfs_out_t;

  typedef struct packed {
    logic first;
    logic advance;
  } trial_ctl_t;

  typedef struct packed {
    logic [4:0]        heads;
    logic [7:0]        spt;
    logic [DIVR_W-1:0] divisor;
    logic              last;
    logic              fit;
  } trial_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_OUT
  } gfs_state_t;

  function automatic logic [7:0] spt_of(input logic [1:0] idx);
    logic [7:0] spt;
    case (idx)
      2'd0:    spt = 8'd63;
      2'd1:    spt = 8'd127;
      default: spt = 8'd255;
    endcase
    return spt;
  endfunction

endpackage

// ----- src/disk_geometry_from_size.sv -----
// Top level: guesses a cylinder/head/sector geometry from a disk image size.
//
// An input transaction is taken at a rising edge with start high and busy low.
// in_item carries the image size in bytes and the image mode. busy stays high
// until the result has been shown. The result appears on out_item for exactly
// one cycle with out_valid high; the receiver cannot stall it.
//
// An empty file image and a synthesized-RDB image finish at once: out_valid is
// high in the cycle after the accepting edge. Other images run through
// trials of sectors per track (63, 127, 255) and heads (4 to 16). Each trial
// divides the 31-bit sector count on a bit-serial divider: a load step, the
// quotient bits one at a time, then a step to judge the result. There are 1
// to 39 trials. One transaction is in work at a time.
//
// Reset is synchronous and active low; it returns the block to idle with no
// result pending.
module disk_geometry_from_size
  import gfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  gfs_in_t  in_item,
  output logic     out_valid,
  output gfs_out_t out_item
);

  gfs_state_t         state_r, state_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               small_r, small_nxt;
  gfs_out_t           res_r, res_nxt;
  trial_ctl_t         tctl;
  trial_sts_t         tsts;
  logic               div_go;
  logic               div_done;
  logic [TOTAL_W-1:0] quotient;
  logic [26:0]        rdb_cyl;

  gfs_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (total_r),
    .divisor  (tsts.divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  gfs_trial u_trial (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tctl),
    .quotient  (quotient),
    .small_img (small_r),
    .sts       (tsts)
  );

  always_comb begin
    state_nxt    = state_r;
    total_nxt    = total_r;
    small_nxt    = small_r;
    res_nxt      = res_r;
    tctl.first   = 1'b0;
    tctl.advance = 1'b0;
    div_go       = 1'b0;
    rdb_cyl      = {1'b0, in_item.image_bytes[39:14]} + 27'd1;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if ((in_item.image_mode inside {MODE_PLAIN, MODE_RDB}) &&
              (in_item.image_bytes == 40'd0)) begin
            res_nxt   = '0;
            state_nxt = ST_OUT;
          end else if (in_item.image_mode == MODE_RDB) begin
            res_nxt.updated           = 1'b1;
            res_nxt.cylinders         = rdb_cyl[15:0];
            res_nxt.heads             = RDB_HEAD_COUNT;
            res_nxt.sectors_per_track = RDB_SPT;
            res_nxt.overflow          = |rdb_cyl[26:16];
            state_nxt                 = ST_OUT;
          end else begin
            total_nxt  = (in_item.image_mode == MODE_PLAIN) ?
                         in_item.image_bytes[39:9] : '0;
            small_nxt  = (total_nxt <= SMALL_IMAGE_SECTORS);
            tctl.first = 1'b1;
            state_nxt  = ST_LAUNCH;
          end
        end
      end
      ST_LAUNCH: begin
        div_go    = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          if (tsts.fit || tsts.last) begin
            res_nxt.updated           = 1'b1;
            res_nxt.cylinders         = quotient[15:0];
            res_nxt.heads             = tsts.fit ? tsts.heads : HEADS_NONE;
            res_nxt.sectors_per_track = tsts.spt;
            res_nxt.overflow          = !tsts.fit || (|quotient[TOTAL_W-1:16]);
            state_nxt                 = ST_OUT;
          end else begin
            tctl.advance = 1'b1;
            state_nxt    = ST_LAUNCH;
          end
        end
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    small_r <= small_nxt;
    res_r   <= res_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_item  = res_r;

endmodule

// ----- src/gfs_divider.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module gfs_divider
  import gfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [TOTAL_W-1:0] dividend,
  input  logic [DIVR_W-1:0]  divisor,
  output logic               done,
  output logic [TOTAL_W-1:0] quotient
);

  logic [DIVR_W-1:0]  rem_r, rem_nxt;
  logic [DIVR_W-1:0]  div_r, div_nxt;
  logic [TOTAL_W-1:0] dvd_r, dvd_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [DIVR_W:0]    trial;
  logic               qbit;

  always_comb begin
    trial    = {rem_r, dvd_r[TOTAL_W-1]};
    qbit     = (trial >= {1'b0, div_r});
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (run_r) begin
      rem_nxt = qbit ? DIVR_W'(trial - {1'b0, div_r}) : trial[DIVR_W-1:0];
      dvd_nxt = {dvd_r[TOTAL_W-2:0], qbit};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (go) begin
      rem_nxt = '0;
      div_nxt = divisor;
      dvd_nxt = dividend;
      cnt_nxt = 5'(TOTAL_W - 1);
      run_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    dvd_r <= dvd_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ----- src/gfs_trial.sv -----
// Trial sequencer: steps heads and sectors per track and checks each cylinder count.
module gfs_trial
  import gfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  trial_ctl_t         ctl,
  input  logic [TOTAL_W-1:0] quotient,
  input  logic               small_img,
  output trial_sts_t         sts
);

  logic [4:0] heads_r, heads_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] spt;

  always_comb begin
    heads_nxt = heads_r;
    idx_nxt   = idx_r;
    if (ctl.first) begin
      heads_nxt = HEADS_MIN;
      idx_nxt   = 2'd0;
    end else if (ctl.advance) begin
      if (heads_r == HEADS_MAX) begin
        heads_nxt = HEADS_MIN;
        idx_nxt   = idx_r + 2'd1;
      end else begin
        heads_nxt = heads_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heads_r <= HEADS_MIN;
      idx_r   <= 2'd0;
    end else begin
      heads_r <= heads_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    spt         = spt_of(idx_r);
    sts.heads   = heads_r;
    sts.spt     = spt;
    sts.divisor = {8'b0, heads_r} * {5'b0, spt};
    sts.last    = (heads_r == HEADS_MAX) && (idx_r == SPT_LAST_IDX);
    if (small_img) begin
      sts.fit = (quotient <= SMALL_CYL_MAX);
    end else begin
      sts.fit = (quotient < CYL_LIMIT_A) ||
                ((quotient < CYL_LIMIT_B) && (heads_r >= 5'd5)) ||
                (quotient <= CYL_LIMIT_C);
    end
  end

endmodule

// ----- src/gfs_checker.sv -----
// Port-level checker for the disk geometry block, bound to the top level.
module gfs_checker
  import gfs_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input gfs_out_t out_item
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("Accepted transaction did not raise busy.");

  a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("Result shown while idle.");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe lasted more than one cycle.");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.updated |->
      out_item.cylinders == 16'd0 && out_item.heads == 5'd0 &&
      out_item.sectors_per_track == 8'd0 && !out_item.overflow)
    else $error("Unchanged geometry carried nonzero fields.");

  a_no_fit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.heads == HEADS_NONE |->
      out_item.overflow && out_item.sectors_per_track == 8'd255)
    else $error("Failed search without overflow flag.");

endmodule

bind disk_geometry_from_size gfs_checker u_gfs_checker (.*);
